[rtl/mprq_pkg.sv]
package mprq_pkg;

	localparam logic [1:0] MODE_INSERT     = 2'd0;
	localparam logic [1:0] MODE_REMOVE_MIN = 2'd1;
	localparam logic [1:0] MODE_PURGE      = 2'd2;

	localparam logic [1:0] STATUS_DONE      = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] handle;
		logic [7:0] prio;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] out_handle;
		logic [7:0] out_prio;
		logic       is_empty;
		logic [4:0] occupancy;
	} rsp_item_t;

	typedef struct packed {
		logic [7:0] handle;
		logic [7:0] prio;
	} slot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic latch_req;
		logic do_start;
		logic do_scan;
		logic do_shift;
		logic load_rsp;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op_mode;
		logic       count_zero;
		logic       gap_found;
		logic       scan_miss;
		logic       shift_more;
		logic       rsp_free;
	} sts_t;

endpackage

[rtl/mprq_req_if.sv]
interface mprq_req_if;
	logic                 valid;
	logic                 ready;
	mprq_pkg::req_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/mprq_rsp_if.sv]
interface mprq_rsp_if;
	logic                 valid;
	logic                 ready;
	mprq_pkg::rsp_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/mprq_ctrl.sv]
module mprq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  mprq_pkg::sts_t   sts,
	output mprq_pkg::cmd_t   cmd
);

	mprq_pkg::state_t state_q;
	mprq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mprq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			mprq_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch_req = 1'b1;
					state_d       = mprq_pkg::ST_START;
				end
			end
			mprq_pkg::ST_START: begin
				cmd.do_start = 1'b1;
				case (sts.op_mode)
					mprq_pkg::MODE_REMOVE_MIN, mprq_pkg::MODE_PURGE: begin
						state_d = sts.count_zero ? mprq_pkg::ST_FINISH : mprq_pkg::ST_SCAN;
					end
					default: begin
						state_d = mprq_pkg::ST_FINISH;
					end
				endcase
			end
			mprq_pkg::ST_SCAN: begin
				cmd.do_scan = 1'b1;
				if (sts.gap_found) begin
					state_d = mprq_pkg::ST_SHIFT;
				end else if (sts.scan_miss) begin
					state_d = mprq_pkg::ST_FINISH;
				end
			end
			mprq_pkg::ST_SHIFT: begin
				cmd.do_shift = 1'b1;
				if (!sts.shift_more) begin
					state_d = mprq_pkg::ST_FINISH;
				end
			end
			mprq_pkg::ST_FINISH: begin
				if (sts.rsp_free) begin
					cmd.load_rsp = 1'b1;
					state_d      = mprq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mprq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/mprq_dp.sv]
module mprq_dp #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mprq_pkg::req_item_t  req_data,
	input  mprq_pkg::cmd_t       cmd,
	output mprq_pkg::sts_t       sts,
	output logic                 rsp_valid,
	output mprq_pkg::rsp_item_t  rsp_data,
	input  logic                 rsp_ready
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	mprq_pkg::slot_t mem [QUEUE_DEPTH];

	mprq_pkg::req_item_t  op_q;
	logic [CW-1:0]        count_q;
	logic [IW-1:0]        scan_idx_q;
	logic [IW-1:0]        best_idx_q;
	mprq_pkg::slot_t      best_q;
	logic [IW-1:0]        wr_idx_q;
	mprq_pkg::slot_t      rd_data_q;
	logic [1:0]           res_status_q;
	mprq_pkg::slot_t      res_slot_q;
	logic                 rsp_valid_q;
	mprq_pkg::rsp_item_t  rsp_data_q;

	logic                 full;
	logic                 scan_last;
	logic                 take;
	logic [IW-1:0]        nb_idx;
	mprq_pkg::slot_t      nb;
	logic                 hit;
	logic                 is_purge;
	logic                 is_min;
	logic                 gap_found;
	logic [IW-1:0]        gap_idx;
	logic                 shift_more;
	logic [IW-1:0]        rd_addr;
	logic                 mem_we;
	logic [IW-1:0]        mem_waddr;
	mprq_pkg::slot_t      mem_wdata;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign is_purge   = (op_q.mode == mprq_pkg::MODE_PURGE);
	assign is_min     = (op_q.mode == mprq_pkg::MODE_REMOVE_MIN);
	assign scan_last  = ((CW'(scan_idx_q) + CW'(1)) == count_q);
	assign take       = (scan_idx_q == '0) || (rd_data_q.prio < best_q.prio);
	assign nb_idx     = take ? scan_idx_q : best_idx_q;
	assign nb         = take ? rd_data_q : best_q;
	assign hit        = (rd_data_q.handle == op_q.handle);
	assign gap_found  = (is_min && scan_last) || (is_purge && hit);
	assign gap_idx    = is_purge ? scan_idx_q : nb_idx;
	assign shift_more = ((CW'(wr_idx_q) + CW'(1)) < count_q);

	assign sts.op_mode    = op_q.mode;
	assign sts.count_zero = (count_q == '0);
	assign sts.gap_found  = gap_found;
	assign sts.scan_miss  = is_purge && !hit && scan_last;
	assign sts.shift_more = shift_more;
	assign sts.rsp_free   = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	always_comb begin
		rd_addr   = '0;
		mem_we    = 1'b0;
		mem_waddr = wr_idx_q;
		mem_wdata = rd_data_q;
		if (cmd.do_scan) begin
			rd_addr = gap_found ? (gap_idx + IW'(1)) : (scan_idx_q + IW'(1));
		end else if (cmd.do_shift) begin
			rd_addr = wr_idx_q + IW'(2);
			mem_we  = shift_more;
		end
		if (cmd.do_start && (op_q.mode == mprq_pkg::MODE_INSERT) && !full) begin
			mem_we    = 1'b1;
			mem_waddr = count_q[IW-1:0];
			mem_wdata.handle = op_q.handle;
			mem_wdata.prio   = op_q.prio;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			op_q <= req_data;
		end
		if (cmd.do_start) begin
			scan_idx_q   <= '0;
			res_slot_q   <= '0;
			res_status_q <= (op_q.mode != mprq_pkg::MODE_INSERT) ? mprq_pkg::STATUS_NOT_FOUND :
				full ? mprq_pkg::STATUS_FULL : mprq_pkg::STATUS_DONE;
		end
		if (cmd.do_scan) begin
			scan_idx_q <= scan_idx_q + IW'(1);
			best_idx_q <= nb_idx;
			best_q     <= nb;
			if (gap_found) begin
				wr_idx_q     <= gap_idx;
				res_status_q <= mprq_pkg::STATUS_DONE;
				res_slot_q   <= is_purge ? rd_data_q : nb;
			end
		end
		if (cmd.do_shift && shift_more) begin
			wr_idx_q <= wr_idx_q + IW'(1);
		end
		if (cmd.load_rsp) begin
			rsp_data_q.status     <= res_status_q;
			rsp_data_q.out_handle <= res_slot_q.handle;
			rsp_data_q.out_prio   <= res_slot_q.prio;
			rsp_data_q.is_empty   <= (count_q == '0);
			rsp_data_q.occupancy  <= 5'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.do_start && (op_q.mode == mprq_pkg::MODE_INSERT) && !full) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.do_shift && !shift_more) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/min_priority_ready_queue_top.sv]
// Bounded ready queue of up to QUEUE_DEPTH process handles, each stored with a priority.
// A request transaction on req carries mode, handle and prio: mode 0 appends at the tail,
// mode 1 removes the entry with the smallest priority (oldest first on ties), and mode 2
// removes the first entry whose handle matches. Every request yields exactly one response
// transaction on rsp with status, the removed handle and priority, is_empty and occupancy.
// Entries live in a single-port-write, single-port-read memory; a sequencer walks it.
// Requests are handled one at a time. A removal first reads entries one per cycle until the
// target is known (all entries for mode 1, up to the match for mode 2), then moves every
// later entry forward one per cycle. The memory read port sets this pace: one entry is
// examined or moved per cycle. The next request can be accepted in the same cycle as the
// response appears.
// The response sits in an output register; a new request is accepted as soon as the
// previous one has been placed there, even while rsp is stalled. If the receiver keeps
// rsp.ready low, the next response waits in the sequencer and req stays not ready.
// Reset empties the queue and drops any pending response; memory contents are not cleared.
module min_priority_ready_queue_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	mprq_req_if.sink   req,
	mprq_rsp_if.source rsp
);

	mprq_pkg::cmd_t cmd;
	mprq_pkg::sts_t sts;
	logic           req_ready;
	logic           rsp_valid;

	mprq_pkg::rsp_item_t rsp_data;

	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;
	assign rsp.data  = rsp_data;

	mprq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mprq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data),
		.rsp_ready (rsp.ready)
	);

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int DEPTH = 16;
	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 4 * DEPTH + 20;
	localparam int ITEMS_PER_PHASE = 270;

	class queue_scoreboard;
		mprq_pkg::slot_t     slots[$];
		mprq_pkg::rsp_item_t expected[$];
		int                  errors;

		function new();
			errors = 0;
		endfunction

		function void note_request(mprq_pkg::req_item_t r);
			mprq_pkg::rsp_item_t e;
			mprq_pkg::slot_t     s;
			int                  best;
			bit                  found;
			e = '0;
			e.status = mprq_pkg::STATUS_NOT_FOUND;
			found = 1'b0;
			case (r.mode)
				mprq_pkg::MODE_INSERT: begin
					if (slots.size() >= DEPTH) begin
						e.status = mprq_pkg::STATUS_FULL;
					end else begin
						s.handle = r.handle;
						s.prio = r.prio;
						slots.push_back(s);
						e.status = mprq_pkg::STATUS_DONE;
					end
				end
				mprq_pkg::MODE_REMOVE_MIN: begin
					if (slots.size() > 0) begin
						best = 0;
						for (int i = 1; i < slots.size(); i++) begin
							if (slots[i].prio < slots[best].prio)
								best = i;
						end
						e.out_handle = slots[best].handle;
						e.out_prio = slots[best].prio;
						slots.delete(best);
						e.status = mprq_pkg::STATUS_DONE;
					end
				end
				mprq_pkg::MODE_PURGE: begin
					for (int i = 0; i < slots.size() && !found; i++) begin
						if (slots[i].handle == r.handle) begin
							e.out_handle = slots[i].handle;
							e.out_prio = slots[i].prio;
							slots.delete(i);
							e.status = mprq_pkg::STATUS_DONE;
							found = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
			e.is_empty = (slots.size() == 0);
			e.occupancy = 5'(slots.size());
			expected.push_back(e);
		endfunction

		function void check_field(string name, int exp_val, int act_val);
			if (exp_val != act_val) begin
				$display("%0t: mismatch on %s, expected %0d, actual %0d",
					$time, name, exp_val, act_val);
				errors++;
			end
		endfunction

		function void check_response(mprq_pkg::rsp_item_t a);
			mprq_pkg::rsp_item_t e;
			if (expected.size() == 0) begin
				$display("%0t: response with nothing expected, actual %p", $time, a);
				errors++;
				return;
			end
			e = expected.pop_front();
			check_field("status", int'(e.status), int'(a.status));
			check_field("out_handle", int'(e.out_handle), int'(a.out_handle));
			check_field("out_prio", int'(e.out_prio), int'(a.out_prio));
			check_field("is_empty", int'(e.is_empty), int'(a.is_empty));
			check_field("occupancy", int'(e.occupancy), int'(a.occupancy));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   stall_pct;
	int   quiet_cycles;
	bit   filling;

	mprq_req_if req();
	mprq_rsp_if rsp();

	queue_scoreboard sb = new();

	min_priority_ready_queue_top #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (rsp.valid && rsp.ready)
			sb.check_response(rsp.data);
		if (req.valid && req.ready)
			sb.note_request(req.data);
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[min_priority_ready_queue_top] ERROR");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [1:0] mode, input logic [7:0] handle,
			input logic [7:0] prio);
		mprq_pkg::req_item_t item;
		item.mode = mode;
		item.handle = handle;
		item.prio = prio;
		if ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req.valid <= 1'b1;
		req.data <= item;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic send_random_request();
		logic [1:0] mode;
		logic [7:0] handle;
		logic [7:0] prio;
		int         pick;
		int         held;
		held = sb.slots.size();
		if (held >= DEPTH && $urandom_range(3) == 0)
			filling = 1'b0;
		else if (held == 0 && $urandom_range(3) == 0)
			filling = 1'b1;
		else if ($urandom_range(99) < 3)
			filling = !filling;
		pick = $urandom_range(99);
		if (pick < 2)
			mode = MODE_NOP;
		else if (filling)
			mode = (pick < 62) ? mprq_pkg::MODE_INSERT :
				(pick < 80) ? mprq_pkg::MODE_REMOVE_MIN : mprq_pkg::MODE_PURGE;
		else
			mode = (pick < 22) ? mprq_pkg::MODE_INSERT :
				(pick < 60) ? mprq_pkg::MODE_REMOVE_MIN : mprq_pkg::MODE_PURGE;
		handle = ($urandom_range(1) == 0) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
		prio = ($urandom_range(99) < 40) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
		if (mode == mprq_pkg::MODE_PURGE && held > 0 && $urandom_range(99) < 75)
			handle = sb.slots[$urandom_range(held - 1)].handle;
		send_request(mode, handle, prio);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		filling = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue, the unused mode, extremes, ties and duplicate handles.
		send_request(mprq_pkg::MODE_REMOVE_MIN, 8'hFF, 8'hFF);
		send_request(mprq_pkg::MODE_PURGE, 8'h00, 8'h00);
		send_request(MODE_NOP, 8'hFF, 8'hFF);
		send_request(mprq_pkg::MODE_INSERT, 8'h00, 8'hFF);
		send_request(mprq_pkg::MODE_INSERT, 8'hFF, 8'h00);
		send_request(mprq_pkg::MODE_INSERT, 8'h07, 8'h00);
		send_request(mprq_pkg::MODE_INSERT, 8'h00, 8'h0A);
		send_request(mprq_pkg::MODE_PURGE, 8'h00, 8'hFF);
		send_request(mprq_pkg::MODE_PURGE, 8'h63, 8'h00);
		send_request(mprq_pkg::MODE_REMOVE_MIN, 8'h00, 8'h00);
		for (int i = 0; i < DEPTH - 2; i++)
			send_request(mprq_pkg::MODE_INSERT, 8'(8'h10 + i), 8'($urandom_range(255)));
		send_request(mprq_pkg::MODE_INSERT, 8'hAA, 8'h55);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 73 : (ph == 3) ? 35 : 0;
			stall_pct = (ph == 2) ? 73 : (ph == 3) ? 35 : 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_random_request();
		end
		req.valid <= 1'b0;

		while (sb.expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("[min_priority_ready_queue_top] OK");
		else
			$display("[min_priority_ready_queue_top] ERROR");
		$finish;
	end
endmodule
